[design/frct_pkg.sv]
// ----------------------------------------------------------------------------
// frct_pkg
// Shared types and constants for the frame reference count table.
// ----------------------------------------------------------------------------
`default_nettype none

package frct_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 32;
  localparam int COUNT_W = 16;
  localparam int OP_W    = 2;

  // Saturation limit of a stored count
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_GET   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_SHARE = 2'd2;
  localparam logic [OP_W-1:0] OP_DROP  = 2'd3;

  // Classified command handed from front to back (slot travels alongside)
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic               in_window;
    logic [COUNT_W-1:0] set_value;
  } cmd_t;

endpackage

`default_nettype wire

[design/frct_ifs.sv]
// ----------------------------------------------------------------------------
// frct_ifs
// Request and response channel interfaces (valid/ready handshake).
// ----------------------------------------------------------------------------
`default_nettype none

interface frct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] frame_address;
  logic [31:0] new_count;

  modport source (output valid, output opcode, output frame_address, output new_count,
                  input ready);
  modport sink   (input valid, input opcode, input frame_address, input new_count,
                  output ready);
endinterface

interface frct_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] reference_count;
  logic        in_window;

  modport source (output valid, output reference_count, output in_window, input ready);
  modport sink   (input valid, input reference_count, input in_window, output ready);
endinterface

`default_nettype wire

[design/frct_ram.sv]
// ----------------------------------------------------------------------------
// frct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/frct_front.sv]
// ----------------------------------------------------------------------------
// frct_front
// Accepts request transactions, works out the table slot and window hit,
// saturates the set value and pushes the command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module frct_front #(
  parameter int WINDOW_FRAMES = 32768,
  parameter int PAGE_BITS     = 12
) (
  frct_req_if.sink                            req,
  input  wire logic                           clearing,
  input  wire logic                           q_full,
  output logic                                push,
  output frct_pkg::cmd_t                      cmd,
  output logic [$clog2(WINDOW_FRAMES)-1:0]    slot
);
  import frct_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_FRAMES);

  logic [ADDR_W-1:0] page_number;

  // Accept while the queue has room and the table is not being cleared
  assign req.ready = !clearing && !q_full;
  assign push      = req.valid && req.ready;

  // Classify
  assign page_number = req.frame_address >> PAGE_BITS;
  assign slot        = SLOT_W'(page_number);

  always_comb begin
    cmd.opcode    = req.opcode;
    cmd.in_window = ({1'b0, page_number} < (ADDR_W+1)'(WINDOW_FRAMES));
    if (req.new_count > REQ_W'(COUNT_MAX)) begin
      cmd.set_value = COUNT_MAX;
    end else begin
      cmd.set_value = req.new_count[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/frct_queue.sv]
// ----------------------------------------------------------------------------
// frct_queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module frct_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign rdata     = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/frct_back.sv]
// ----------------------------------------------------------------------------
// frct_back
// Clears the count table after reset, then executes queued commands as a
// read-modify-write of one entry and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frct_back #(
  parameter int WINDOW_FRAMES = 32768
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_not_empty,
  input  wire frct_pkg::cmd_t              q_cmd,
  input  wire logic [$clog2(WINDOW_FRAMES)-1:0] q_slot,
  output logic                             pop,
  output logic                             clearing,
  frct_rsp_if.source                       rsp
);
  import frct_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_FRAMES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_FRAMES - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_MODIFY = 2'd2;

  logic [1:0]         state;
  logic [SLOT_W-1:0]  clr_addr;
  cmd_t               cur_cmd;
  logic [SLOT_W-1:0]  cur_slot;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_window;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] result;

  assign clearing = (state == S_CLEAR);

  // Issue a command once the output register will be free
  assign pop = (state == S_IDLE) && q_not_empty && (!out_valid || rsp.ready);

  frct_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (WINDOW_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_slot),
    .rdata (ram_rdata)
  );

  // Update of the stored count; for share and drop an untracked (zero) count counts as one
  always_comb begin
    eff_count = (ram_rdata == '0) ? COUNT_W'(1) : ram_rdata;
    case (cur_cmd.opcode)
      OP_GET:   result = ram_rdata;
      OP_SET:   result = cur_cmd.set_value;
      OP_SHARE: result = (eff_count == COUNT_MAX) ? COUNT_MAX : eff_count + COUNT_W'(1);
      OP_DROP:  result = eff_count - COUNT_W'(1);
      default:  result = ram_rdata;
    endcase
  end

  // RAM write: zero sweep while clearing, otherwise the modified entry
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_MODIFY) && cur_cmd.in_window && (cur_cmd.opcode != OP_GET);
      ram_waddr = cur_slot;
      ram_wdata = result;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == LAST_SLOT) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) state <= S_MODIFY;
        end
        S_MODIFY: begin
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Command held through the read
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd  <= q_cmd;
      cur_slot <= q_slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_MODIFY) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MODIFY) begin
      out_window <= cur_cmd.in_window;
      if (cur_cmd.in_window) begin
        out_count <= result;
      end else begin
        out_count <= (cur_cmd.opcode == OP_DROP) ? COUNT_W'(1) : '0;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.reference_count = out_count;
  assign rsp.in_window       = out_window;

endmodule

`default_nettype wire

[design/frame_reference_count_table.sv]
// ----------------------------------------------------------------------------
// frame_reference_count_table
// Table of 16-bit reference counts, one per page frame inside the window.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request transaction (opcode, frame_address, new_count);
//   rsp returns exactly one transaction per request, in request order,
//   carrying reference_count and in_window.
//   Requests are classified on entry and wait in a two-entry queue; the
//   execution side reads the entry, modifies it and writes it back.
//   Path: an accepted request passes the queue, the registered read of the
//   count RAM and the output register. The execution side starts a command
//   only once the previous one is written back (read, then write-back).
//   Reset: the table is swept to zero, one entry per cycle, and req.ready
//   stays low during that sweep.
//   A stalled receiver holds the result in the output register; up to two
//   further requests are still taken into the queue meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_reference_count_table #(
  parameter int WINDOW_FRAMES = 32768,
  parameter int PAGE_BITS     = 12
) (
  input  wire logic   clk,
  input  wire logic   rst,
  frct_req_if.sink    req,
  frct_rsp_if.source  rsp
);
  import frct_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_FRAMES);
  localparam int Q_W    = $bits(cmd_t) + SLOT_W;

  logic              push;
  cmd_t              f_cmd;
  logic [SLOT_W-1:0] f_slot;
  logic              q_full;
  logic              q_not_empty;
  logic [Q_W-1:0]    q_data;
  cmd_t              q_cmd;
  logic [SLOT_W-1:0] q_slot;
  logic              pop;
  logic              clearing;

  frct_front #(
    .WINDOW_FRAMES (WINDOW_FRAMES),
    .PAGE_BITS     (PAGE_BITS)
  ) u_front (
    .req      (req),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .cmd      (f_cmd),
    .slot     (f_slot)
  );

  frct_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_cmd, f_slot}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rdata     (q_data)
  );

  assign q_cmd  = q_data[Q_W-1:SLOT_W];
  assign q_slot = q_data[SLOT_W-1:0];

  frct_back #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_cmd),
    .q_slot      (q_slot),
    .pop         (pop),
    .clearing    (clearing),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

[sim/frame_reference_count_table_tb.sv]
// ----------------------------------------------------------------------------
// frame_reference_count_table_tb
// Self-checking bench for the frame reference count table. A shadow copy of
// the count table predicts every response. Directed requests cover the window
// edges, saturation and untracked frames. Random traffic then works mostly on
// a few hot frames, with random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_reference_count_table_tb;
  import frct_pkg::*;

  localparam int WINDOW_FRAMES = 32768;
  localparam int PAGE_BITS     = 12;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOT_FRAMES    = 8;

  typedef struct packed {
    logic [COUNT_W-1:0] reference_count;
    logic               in_window;
  } count_result_t;

  // Shadow count table plus the queue of responses still owed by the block
  class frame_count_scoreboard;
    logic [COUNT_W-1:0] shadow_counts [WINDOW_FRAMES];
    count_result_t      owed_results [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        outside_seen;
    int unsigned        saturated_seen;
    int unsigned        op_tally [4];

    function new();
      foreach (shadow_counts[k]) shadow_counts[k] = '0;
      foreach (op_tally[k]) op_tally[k] = 0;
      mismatches     = 0;
      checked        = 0;
      outside_seen   = 0;
      saturated_seen = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Work out the response for one accepted request and update the shadow
    function void note_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [REQ_W-1:0] value);
      logic [ADDR_W-1:0]  slot;
      logic [COUNT_W-1:0] cur;
      count_result_t      res;
      slot = addr >> PAGE_BITS;
      op_tally[op]++;
      if (slot >= WINDOW_FRAMES) begin
        // outside the window: table untouched, drop reports one
        res.reference_count = (op == OP_DROP) ? 16'd1 : 16'd0;
        res.in_window       = 1'b0;
        outside_seen++;
      end else begin
        cur           = shadow_counts[slot];
        res.in_window = 1'b1;
        case (op)
          OP_GET: begin
            res.reference_count = cur;
          end
          OP_SET: begin
            res.reference_count = (value > REQ_W'(COUNT_MAX)) ? COUNT_MAX : value[COUNT_W-1:0];
          end
          OP_SHARE: begin
            if (cur == '0) cur = 16'd1;
            res.reference_count = (cur == COUNT_MAX) ? COUNT_MAX : cur + 16'd1;
          end
          default: begin
            if (cur == '0) cur = 16'd1;
            res.reference_count = cur - 16'd1;
          end
        endcase
        if (op != OP_GET) shadow_counts[slot] = res.reference_count;
        if (res.reference_count == COUNT_MAX) saturated_seen++;
      end
      owed_results.push_back(res);
    endfunction

    // Compare one accepted response with the oldest owed one
    task check_response(input logic [COUNT_W-1:0] count, input logic in_win);
      count_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected response count=%0d in_window=%0b",
                                  count, in_win));
      end else begin
        want = owed_results.pop_front();
        checked++;
        if (count !== want.reference_count)
          report_mismatch($sformatf("response %0d reference_count %0d, want %0d",
                                    checked, count, want.reference_count));
        if (in_win !== want.in_window)
          report_mismatch($sformatf("response %0d in_window %0b, want %0b",
                                    checked, in_win, want.in_window));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   steady;     // when set, neither side idles

  frct_req_if req_ch ();
  frct_rsp_if rsp_ch ();

  frame_count_scoreboard sb = new();

  frame_reference_count_table #(
    .WINDOW_FRAMES (WINDOW_FRAMES),
    .PAGE_BITS     (PAGE_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: covers the reset sweep plus worst-case gaps several times over
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // One request transaction: optional gap, then hold valid until accepted
  task send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                    input logic [REQ_W-1:0] value);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.frame_address <= addr;
    req_ch.new_count     <= value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, addr, value);
  endtask

  // Response side: random stall before each transaction, then check it
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      sb.check_response(rsp_ch.reference_count, rsp_ch.in_window);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    logic [ADDR_W-1:0] hot_frame [HOT_FRAMES];
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [REQ_W-1:0]  value;
    logic [OP_W-1:0]   op;
    int unsigned       pick;
    int unsigned       drain;

    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_GET;
    req_ch.frame_address = '0;
    req_ch.new_count     = '0;
    rst                  = 1'b1;
    steady               = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: untracked frames, saturation, window edges, ignored fields
    send_request(OP_GET,   32'h0000_0000, 32'h0000_0000);
    send_request(OP_SHARE, 32'h0000_1000, 32'h0000_0000);
    send_request(OP_DROP,  32'h0000_2FFF, 32'hFFFF_FFFF);
    send_request(OP_SET,   32'h0000_3000, 32'hFFFF_FFFF);
    send_request(OP_SHARE, 32'h0000_3ABC, 32'h0000_0000);
    send_request(OP_DROP,  32'h0000_3000, 32'h0000_0000);
    send_request(OP_GET,   32'h0000_3FFF, 32'h1234_5678);
    send_request(OP_SET,   32'h0000_4000, 32'h0001_0000);
    send_request(OP_SET,   32'h0000_4000, 32'h0000_0000);
    send_request(OP_DROP,  32'h0000_4000, 32'h0000_0000);
    send_request(OP_SET,   32'h0000_5000, 32'h0000_FFFF);
    send_request(OP_SET,   32'h07FF_FFFF, 32'h0000_0007);
    send_request(OP_GET,   32'h07FF_F000, 32'h0000_0000);
    send_request(OP_GET,   32'h0800_0000, 32'h0000_0000);
    send_request(OP_SET,   32'h0800_0000, 32'h0000_0005);
    send_request(OP_SHARE, 32'h0800_0FFF, 32'h0000_0000);
    send_request(OP_DROP,  32'h0800_0000, 32'h0000_0000);
    send_request(OP_DROP,  32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET,   32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(OP_SET,   32'h0000_6000, 32'h0000_0001);
    send_request(OP_DROP,  32'h0000_6000, 32'h0000_0000);
    send_request(OP_DROP,  32'h0000_6000, 32'h0000_0000);
    send_request(OP_SHARE, 32'h0000_7000, 32'h0000_0000);
    send_request(OP_SHARE, 32'h0000_7000, 32'h0000_0000);
    send_request(OP_GET,   32'h0000_7000, 32'h0000_0000);

    // Hot frames keep counts building up; the window edges are always among them
    hot_frame[0] = 0;
    hot_frame[1] = WINDOW_FRAMES - 1;
    for (int k = 2; k < HOT_FRAMES; k++) hot_frame[k] = $urandom_range(0, WINDOW_FRAMES - 1);

    // Random phases, alternating idle-free and gappy traffic
    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase % 2 == 0);
      if (phase == 3) begin
        // sender drops valid and holds off until the block has answered everything
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op   = OP_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          slot = hot_frame[$urandom_range(0, HOT_FRAMES - 1)];
          addr = (slot << PAGE_BITS) | $urandom_range(0, (1 << PAGE_BITS) - 1);
        end else if (pick < 75) begin
          addr = $urandom_range(0, WINDOW_FRAMES * (1 << PAGE_BITS) - 1);
        end else if (pick < 85) begin
          addr = $urandom();
        end else if (pick < 93) begin
          addr = WINDOW_FRAMES * (1 << PAGE_BITS) + $urandom_range(0, 16'hFFFF);
        end else begin
          addr = 32'hFFFF_FFFF - $urandom_range(0, 16'hFFFF);
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)      value = $urandom_range(0, 20);
        else if (pick < 60) value = $urandom_range(65530, 65535);
        else if (pick < 70) value = $urandom_range(65536, 65540);
        else                value = $urandom();
        send_request(op, addr, value);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain, then allow for the block's latency
    drain = 0;
    while (sb.owed_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (sb.owed_results.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.owed_results.size()));

    $display("Covered %0d requests (get %0d, set %0d, share %0d, drop %0d), %0d outside the window",
             sb.checked, sb.op_tally[OP_GET], sb.op_tally[OP_SET], sb.op_tally[OP_SHARE],
             sb.op_tally[OP_DROP], sb.outside_seen);
    $display("Saturated counts seen: %0d, mismatches: %0d", sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
design/frct_pkg.sv
design/frct_ifs.sv
design/frct_ram.sv
design/frct_front.sv
design/frct_queue.sv
design/frct_back.sv
design/frame_reference_count_table.sv
sim/frame_reference_count_table_tb.sv
